/* hw/rtl/sha1sh_pkg.sv */
// Shared types and constants for the SHA-1 stream hasher.
// Used by the controller, the datapath and the top level; depends on nothing.
package sha1sh_pkg;

	localparam int unsigned ROUNDS       = 80;
	localparam int unsigned DIGEST_WORDS = 5;
	localparam int unsigned BLOCK_BYTES  = 64;
	localparam int unsigned LEN_POS      = 56;

	localparam logic [7:0] PAD_BYTE = 8'h80;

	localparam logic [31:0] IV [DIGEST_WORDS] = '{
		32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
	};

	localparam logic [31:0] ROUND_K [4] = '{
		32'h5A827999, 32'h6ED9EBA1, 32'h8F1BBCDC, 32'hCA62C1D6
	};

	typedef enum logic [1:0] {
		SEL_DATA,
		SEL_PAD,
		SEL_ZERO,
		SEL_LEN
	} byte_sel_t;

	typedef struct packed {
		logic       push;
		byte_sel_t  sel;
		logic       load;
		logic       round;
		logic [1:0] stage;
		logic       add;
		logic       init;
		logic [2:0] out_sel;
	} sha1sh_cmd_t;

	typedef struct packed {
		logic block_full;
		logic at_len;
	} sha1sh_sts_t;

endpackage

/* hw/rtl/sha1sh_ctrl.sv */
// Controller state machine for the SHA-1 stream hasher.
// Sequences byte intake, padding, compression rounds and digest output; uses sha1sh_pkg.
module sha1sh_ctrl
	import sha1sh_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        has_byte,
	input  logic        message_end,
	output logic        in_ready,
	input  logic        out_ready,
	output logic        out_valid,
	output logic [2:0]  word_index,
	output logic        last_word,
	input  sha1sh_sts_t sts,
	output sha1sh_cmd_t cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_ROUND,
		ST_ADD,
		ST_PAD80,
		ST_PADZ,
		ST_LEN,
		ST_OUT
	} state_t;

	localparam logic [6:0] LAST_ROUND = 7'(ROUNDS - 1);
	localparam logic [2:0] LAST_IDX   = 3'(DIGEST_WORDS - 1);

	state_t     state_q;
	state_t     ret_q;
	logic [6:0] round_q;
	logic [2:0] idx_q;

	always_comb begin
		cmd         = '0;
		cmd.sel     = SEL_DATA;
		cmd.out_sel = idx_q;
		if (round_q < 7'd20) begin
			cmd.stage = 2'd0;
		end else if (round_q < 7'd40) begin
			cmd.stage = 2'd1;
		end else if (round_q < 7'd60) begin
			cmd.stage = 2'd2;
		end else begin
			cmd.stage = 2'd3;
		end
		case (state_q)
			ST_IDLE: begin
				cmd.push = in_valid && has_byte;
			end
			ST_LOAD: begin
				cmd.load = 1'b1;
			end
			ST_ROUND: begin
				cmd.round = 1'b1;
			end
			ST_ADD: begin
				cmd.add = 1'b1;
			end
			ST_PAD80: begin
				cmd.push = 1'b1;
				cmd.sel  = SEL_PAD;
			end
			ST_PADZ: begin
				cmd.push = !sts.at_len;
				cmd.sel  = SEL_ZERO;
			end
			ST_LEN: begin
				cmd.push = 1'b1;
				cmd.sel  = SEL_LEN;
			end
			ST_OUT: begin
				cmd.init = out_ready && (idx_q == LAST_IDX);
			end
			default: begin
				cmd.push = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ret_q   <= ST_IDLE;
			round_q <= '0;
			idx_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						if (has_byte && sts.block_full) begin
							state_q <= ST_LOAD;
							ret_q   <= message_end ? ST_PAD80 : ST_IDLE;
						end else if (message_end) begin
							state_q <= ST_PAD80;
						end
					end
				end
				ST_LOAD: begin
					round_q <= '0;
					state_q <= ST_ROUND;
				end
				ST_ROUND: begin
					if (round_q == LAST_ROUND) begin
						state_q <= ST_ADD;
					end else begin
						round_q <= round_q + 7'd1;
					end
				end
				ST_ADD: begin
					state_q <= ret_q;
				end
				ST_PAD80: begin
					if (sts.block_full) begin
						state_q <= ST_LOAD;
						ret_q   <= ST_PADZ;
					end else begin
						state_q <= ST_PADZ;
					end
				end
				ST_PADZ: begin
					if (sts.at_len) begin
						state_q <= ST_LEN;
					end else if (sts.block_full) begin
						state_q <= ST_LOAD;
						ret_q   <= ST_PADZ;
					end
				end
				ST_LEN: begin
					if (sts.block_full) begin
						state_q <= ST_LOAD;
						ret_q   <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_ready) begin
						if (idx_q == LAST_IDX) begin
							idx_q   <= '0;
							state_q <= ST_IDLE;
						end else begin
							idx_q <= idx_q + 3'd1;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign in_ready   = (state_q == ST_IDLE);
	assign out_valid  = (state_q == ST_OUT);
	assign word_index = idx_q;
	assign last_word  = (idx_q == LAST_IDX);

endmodule

/* hw/rtl/sha1sh_dp.sv */
// Datapath for the SHA-1 stream hasher: block and schedule shift line, round
// registers, chaining words and message length. Uses sha1sh_pkg.
module sha1sh_dp
	import sha1sh_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic [7:0]  data_byte,
	input  sha1sh_cmd_t cmd,
	output sha1sh_sts_t sts,
	output logic [31:0] digest_word
);

	// The block buffer doubles as the 16-word message schedule window.
	logic [511:0] blk_q;
	logic [31:0]  a_q, b_q, c_q, d_q, e_q;
	logic [31:0]  h_q [DIGEST_WORDS];
	logic [60:0]  cnt_q;
	logic [5:0]   fill_q;

	logic [63:0] bit_len;
	logic [2:0]  len_sel;
	logic [7:0]  push_byte;
	logic [31:0] w0, w2, w8, w13, w_mix, w_next;
	logic [31:0] f_val, t_val;

	assign bit_len = {cnt_q, 3'b000};
	assign len_sel = 3'd7 - fill_q[2:0];

	always_comb begin
		case (cmd.sel)
			SEL_DATA: push_byte = data_byte;
			SEL_PAD:  push_byte = PAD_BYTE;
			SEL_ZERO: push_byte = 8'h00;
			SEL_LEN:  push_byte = bit_len[{len_sel, 3'b000} +: 8];
			default:  push_byte = 8'h00;
		endcase
	end

	assign w0     = blk_q[511:480];
	assign w2     = blk_q[447:416];
	assign w8     = blk_q[255:224];
	assign w13    = blk_q[95:64];
	assign w_mix  = w13 ^ w8 ^ w2 ^ w0;
	assign w_next = {w_mix[30:0], w_mix[31]};

	always_comb begin
		case (cmd.stage)
			2'd0:    f_val = (b_q & c_q) | (~b_q & d_q);
			2'd2:    f_val = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
			default: f_val = b_q ^ c_q ^ d_q;
		endcase
	end

	assign t_val = {a_q[26:0], a_q[31:27]} + e_q + w0 + f_val + ROUND_K[cmd.stage];

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			blk_q <= {blk_q[503:0], push_byte};
		end else if (cmd.round) begin
			blk_q <= {blk_q[479:0], w_next};
		end
		if (cmd.load) begin
			a_q <= h_q[0];
			b_q <= h_q[1];
			c_q <= h_q[2];
			d_q <= h_q[3];
			e_q <= h_q[4];
		end else if (cmd.round) begin
			a_q <= t_val;
			b_q <= a_q;
			c_q <= {b_q[1:0], b_q[31:2]};
			d_q <= c_q;
			e_q <= d_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h_q    <= IV;
			cnt_q  <= '0;
			fill_q <= '0;
		end else begin
			if (cmd.init) begin
				h_q    <= IV;
				cnt_q  <= '0;
				fill_q <= '0;
			end else begin
				if (cmd.add) begin
					h_q[0] <= h_q[0] + a_q;
					h_q[1] <= h_q[1] + b_q;
					h_q[2] <= h_q[2] + c_q;
					h_q[3] <= h_q[3] + d_q;
					h_q[4] <= h_q[4] + e_q;
				end
				if (cmd.push) begin
					fill_q <= fill_q + 6'd1;
					if (cmd.sel == SEL_DATA) begin
						cnt_q <= cnt_q + 61'd1;
					end
				end
			end
		end
	end

	assign sts.block_full = (fill_q == 6'(BLOCK_BYTES - 1));
	assign sts.at_len     = (fill_q == 6'(LEN_POS));
	assign digest_word    = h_q[cmd.out_sel];

endmodule

/* hw/rtl/sha1_stream_hasher_unit.sv */
// SHA-1 stream hasher: one message byte per word, 160-bit digest out as five words.
// Input: a byte is accepted whenever in_ready is high; every 64th byte starts a compression
// (state load, 80 rounds on one round unit, chaining add) during which input stalls.
// Message end: the pad byte, zero bytes up to the length field and the eight length bytes
// are pushed, then one or two more compressions, then five digest words. Reset clears control,
// sets the chaining words to the initial values and the length to zero; no clearing pass.
module sha1_stream_hasher_unit
	import sha1sh_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        has_byte,
	input  logic        message_end,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last_word
);

	sha1sh_cmd_t cmd;
	sha1sh_sts_t sts;

	sha1sh_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.has_byte    (has_byte),
		.message_end (message_end),
		.in_ready    (in_ready),
		.out_ready   (out_ready),
		.out_valid   (out_valid),
		.word_index  (word_index),
		.last_word   (last_word),
		.sts         (sts),
		.cmd         (cmd)
	);

	sha1sh_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.data_byte   (data_byte),
		.cmd         (cmd),
		.sts         (sts),
		.digest_word (digest_word)
	);

endmodule

/* bench/tb_sha1_stream_hasher_unit.sv */
// Testbench for sha1_stream_hasher_unit: byte streams go in, SHA-1 digest words come out.
// A built-in SHA-1 predictor queues the expected words and a checker compares them.
// Depends on sha1sh_pkg and the sha1_stream_hasher_unit RTL.
module tb_sha1_stream_hasher_unit;
	import sha1sh_pkg::*;

	typedef struct packed {
		logic [31:0] value;
		logic [2:0]  index;
		logic        is_last;
	} digest_exp_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  data_byte;
	logic        has_byte;
	logic        message_end;
	logic        out_valid;
	logic        out_ready;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last_word;

	logic [31:0] hash_state [DIGEST_WORDS];
	logic [7:0]  block_buf [BLOCK_BYTES];
	logic [60:0] byte_total;
	digest_exp_t digest_queue [$];

	int mismatches;
	int items_sent;
	int stall_left;
	int hold_left;
	bit tx_gaps;
	bit rx_gaps;

	sha1_stream_hasher_unit DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.data_byte  (data_byte),
		.has_byte   (has_byte),
		.message_end(message_end),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.digest_word(digest_word),
		.word_index (word_index),
		.last_word  (last_word)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic logic [31:0] rol(input logic [31:0] x, input int unsigned n);
		return (x << n) | (x >> (32 - n));
	endfunction

	function automatic void restart_hash();
		for (int i = 0; i < DIGEST_WORDS; i++)
			hash_state[i] = IV[i];
		byte_total = '0;
	endfunction

	function automatic void compress_block();
		logic [31:0] w [16];
		logic [31:0] a, b, c, d, e, f, t;
		for (int i = 0; i < 16; i++)
			w[i] = {block_buf[4*i], block_buf[4*i+1], block_buf[4*i+2], block_buf[4*i+3]};
		a = hash_state[0];
		b = hash_state[1];
		c = hash_state[2];
		d = hash_state[3];
		e = hash_state[4];
		for (int i = 0; i < ROUNDS; i++) begin
			if (i >= 16)
				w[i%16] = rol(w[(i-3)%16] ^ w[(i-8)%16] ^ w[(i-14)%16] ^ w[i%16], 1);
			case (i / 20)
				0: f = (b & c) | (~b & d);
				2: f = (b & c) | (b & d) | (c & d);
				default: f = b ^ c ^ d;
			endcase
			t = rol(a, 5) + e + w[i%16] + f + ROUND_K[i/20];
			e = d;
			d = c;
			c = rol(b, 30);
			b = a;
			a = t;
		end
		hash_state[0] += a;
		hash_state[1] += b;
		hash_state[2] += c;
		hash_state[3] += d;
		hash_state[4] += e;
	endfunction

	function automatic void finish_digest();
		int unsigned pos;
		logic [63:0] bit_len;
		digest_exp_t exp_word;
		pos = 32'(byte_total[5:0]);
		bit_len = {byte_total, 3'b000};
		block_buf[pos] = PAD_BYTE;
		pos++;
		if (pos > LEN_POS) begin
			while (pos < BLOCK_BYTES) begin
				block_buf[pos] = 8'h00;
				pos++;
			end
			compress_block();
			pos = 0;
		end
		while (pos < LEN_POS) begin
			block_buf[pos] = 8'h00;
			pos++;
		end
		for (int i = 0; i < 8; i++)
			block_buf[LEN_POS + i] = bit_len[63 - 8*i -: 8];
		compress_block();
		for (int i = 0; i < DIGEST_WORDS; i++) begin
			exp_word.value = hash_state[i];
			exp_word.index = 3'(i);
			exp_word.is_last = (i == DIGEST_WORDS - 1);
			digest_queue.push_back(exp_word);
		end
		restart_hash();
	endfunction

	function automatic void predict_word(input logic [7:0] b, input logic hb, input logic me);
		if (hb) begin
			block_buf[byte_total[5:0]] = b;
			byte_total = byte_total + 61'd1;
			if (byte_total[5:0] == 6'd0)
				compress_block();
		end
		if (me)
			finish_digest();
	endfunction

	task automatic report(input string msg);
		$display("[%0t] mismatch: %s", $time, msg);
		mismatches++;
	endtask

	always @(posedge clk) begin
		digest_exp_t exp_word;
		if (arst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1) begin
			stall_left = rx_gaps ? $urandom_range(0, 5) : 0;
			if (digest_queue.size() == 0) begin
				report($sformatf("unexpected digest word %h index %0d", digest_word, word_index));
			end else begin
				exp_word = digest_queue.pop_front();
				if (digest_word !== exp_word.value)
					report($sformatf("digest_word got %h expected %h", digest_word,
						exp_word.value));
				if (word_index !== exp_word.index)
					report($sformatf("word_index got %0d expected %0d", word_index,
						exp_word.index));
				if (last_word !== exp_word.is_last)
					report($sformatf("last_word got %b expected %b", last_word,
						exp_word.is_last));
			end
		end
	end

	// The receiver stalls for a drawn number of cycles after each word, or for a long hold.
	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				out_ready <= 1'b0;
				hold_left--;
			end else if (stall_left > 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	task automatic send_word(input logic [7:0] b, input logic hb, input logic me);
		int gap;
		gap = tx_gaps ? $urandom_range(0, 5) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		has_byte <= hb;
		message_end <= me;
		do
			@(posedge clk);
		while (in_ready !== 1'b1);
		predict_word(b, hb, me);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic send_message(input int unsigned len, input bit noisy);
		bit end_on_byte;
		end_on_byte = (len > 0) && $urandom_range(0, 1);
		for (int unsigned i = 0; i < len; i++) begin
			if (noisy && $urandom_range(0, 9) == 0)
				send_word(8'($urandom_range(0, 255)), 1'b0, 1'b0);
			send_word(8'($urandom_range(0, 255)), 1'b1, end_on_byte && (i == len - 1));
		end
		if (!end_on_byte)
			send_word(8'($urandom_range(0, 255)), 1'b0, 1'b1);
	endtask

	task automatic test_empty_and_noise();
		send_word(8'h5A, 1'b0, 1'b0);
		send_word(8'h00, 1'b0, 1'b1);
		send_word(8'hFF, 1'b0, 1'b0);
		send_word(8'hFF, 1'b0, 1'b1);
	endtask

	task automatic test_short_messages();
		send_word(8'h00, 1'b1, 1'b1);
		send_word(8'hFF, 1'b1, 1'b1);
		send_word(8'h61, 1'b1, 1'b0);
		send_word(8'h62, 1'b1, 1'b0);
		send_word(8'h63, 1'b1, 1'b0);
		send_word(8'hA5, 1'b0, 1'b1);
		send_word(8'h80, 1'b1, 1'b0);
		send_word(8'h7F, 1'b0, 1'b0);
		send_word(8'h01, 1'b1, 1'b1);
	endtask

	task automatic test_output_backpressure();
		in_valid <= 1'b0;
		@(posedge clk);
		hold_left = 600;
		@(negedge clk);
		tx_gaps = 1'b0;
		for (int i = 0; i < 5; i++)
			send_message($urandom_range(0, 3), 1'b0);
		tx_gaps = 1'b1;
	endtask

	task automatic test_random_messages();
		int start_count;
		int unsigned len;
		int unsigned pick;
		start_count = items_sent;
		while (items_sent < start_count + 200) begin
			tx_gaps = ($urandom_range(0, 3) != 0);
			rx_gaps = ($urandom_range(0, 3) != 0);
			pick = $urandom_range(0, 9);
			if (pick <= 5)
				len = $urandom_range(0, 15);
			else if (pick <= 8)
				case ($urandom_range(0, 3))
					0: len = 55;
					1: len = 56;
					2: len = 63;
					default: len = 64;
				endcase
			else
				len = $urandom_range(0, 130);
			send_message(len, 1'b1);
		end
		tx_gaps = 1'b1;
		rx_gaps = 1'b1;
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		data_byte = 8'h00;
		has_byte = 1'b0;
		message_end = 1'b0;
		mismatches = 0;
		items_sent = 0;
		stall_left = 0;
		hold_left = 0;
		tx_gaps = 1'b1;
		rx_gaps = 1'b1;
		restart_hash();
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_empty_and_noise();
		test_short_messages();
		test_output_backpressure();
		test_random_messages();

		in_valid <= 1'b0;
		while (digest_queue.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	initial begin
		#2000000;
		$display("FAILURE");
		$finish;
	end

endmodule
